// File: src/rws_pkg.sv
// Shared types and constants for the roulette wheel selection block.
// No dependencies; used by rws_ctrl, rws_datapath and the top level.
package rws_pkg;

  localparam int POP_MAX     = 64;
  localparam int IDX_W       = $clog2(POP_MAX);
  localparam int CNT_W       = $clog2(POP_MAX + 1);
  localparam int FIT_W       = 32;
  localparam int RND_W       = 16;
  localparam int TOT_W       = FIT_W + IDX_W;
  localparam int RHS_W       = TOT_W + RND_W;

  // request operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // result kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef struct packed {
    logic             operation;
    logic             first_entry;
    logic [FIT_W-1:0] fitness;
    logic [RND_W-1:0] random_fraction;
  } in_req_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] selected_index;
    logic [IDX_W-1:0] best_index;
    logic [TOT_W-1:0] total_fitness;
    logic [CNT_W-1:0] entry_total;
    logic             overflow;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // apply a load request
    logic sel_begin;  // start a wheel walk
    logic sel_empty;  // select on an empty store
    logic walk;       // one walk step
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic walk_done;
  } dp_status_t;

endpackage

// File: src/rws_ctrl.sv
// Controller state machine for roulette wheel selection.
// Depends on rws_pkg (command/status structs, operation codes).
module rws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                operation,
  input  rws_pkg::dp_status_t status,
  output rws_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   accept;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign accept    = start && !busy;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (operation == rws_pkg::OP_LOAD) begin
            cmd.load  = 1'b1;
            valid_nxt = 1'b1;
          end else if (status.count_zero) begin
            cmd.sel_empty = 1'b1;
            valid_nxt     = 1'b1;
          end else begin
            cmd.sel_begin = 1'b1;
            state_nxt     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: src/rws_datapath.sv
// Datapath: fitness store, running total, best tracking and wheel walk.
// Depends on rws_pkg (request/result structs, command/status structs).
module rws_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  rws_pkg::in_req_t    in_req,
  input  rws_pkg::dp_cmd_t    cmd,
  output rws_pkg::dp_status_t status,
  output rws_pkg::out_rsp_t   out_rsp
);

  // generation state
  logic [rws_pkg::CNT_W-1:0] count_r;
  logic [rws_pkg::TOT_W-1:0] total_r;
  logic [rws_pkg::IDX_W-1:0] best_slot_r;
  logic [rws_pkg::FIT_W-1:0] best_val_r;

  // fitness store, registered read
  logic [rws_pkg::FIT_W-1:0] mem [rws_pkg::POP_MAX];
  logic [rws_pkg::FIT_W-1:0] rd_data_r;
  logic [rws_pkg::IDX_W-1:0] rd_addr;

  // walk registers
  logic [rws_pkg::RHS_W-1:0] rhs_r;
  logic [rws_pkg::TOT_W-1:0] sum_r;
  logic [rws_pkg::IDX_W-1:0] idx_r;
  rws_pkg::out_rsp_t         rsp_r;

  // load view after an optional generation clear
  logic [rws_pkg::CNT_W-1:0] eff_count;
  logic [rws_pkg::TOT_W-1:0] eff_total;
  logic [rws_pkg::IDX_W-1:0] eff_best_slot;
  logic [rws_pkg::FIT_W-1:0] eff_best_val;
  logic                      full;
  logic [rws_pkg::CNT_W-1:0] count_nxt;
  logic [rws_pkg::TOT_W-1:0] total_nxt;
  logic [rws_pkg::IDX_W-1:0] best_slot_nxt;
  logic [rws_pkg::FIT_W-1:0] best_val_nxt;

  // walk step
  logic [rws_pkg::TOT_W-1:0] sum_nxt;
  logic                      hit;
  logic                      last;

  always_comb begin
    eff_count     = in_req.first_entry ? '0 : count_r;
    eff_total     = in_req.first_entry ? '0 : total_r;
    eff_best_slot = in_req.first_entry ? '0 : best_slot_r;
    eff_best_val  = in_req.first_entry ? '0 : best_val_r;
    full          = (eff_count == rws_pkg::CNT_W'(rws_pkg::POP_MAX));
    count_nxt     = eff_count;
    total_nxt     = eff_total;
    best_slot_nxt = eff_best_slot;
    best_val_nxt  = eff_best_val;
    if (!full) begin
      count_nxt = eff_count + 1'b1;
      total_nxt = eff_total + rws_pkg::TOT_W'(in_req.fitness);
      if (in_req.fitness > eff_best_val) begin
        best_val_nxt  = in_req.fitness;
        best_slot_nxt = eff_count[rws_pkg::IDX_W-1:0];
      end
    end
  end

  // sum * 2^RND_W >= frac * total
  assign sum_nxt = sum_r + rws_pkg::TOT_W'(rd_data_r);
  assign hit     = {sum_nxt, rws_pkg::RND_W'(0)} >= rhs_r;
  assign last    = ({1'b0, idx_r} == (count_r - 1'b1));

  assign status.count_zero = (count_r == '0);
  assign status.walk_done  = hit || last;

  // address the next entry so that its registered read is ready for the next walk step
  assign rd_addr = cmd.walk ? idx_r + 1'b1 : '0;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[eff_count[rws_pkg::IDX_W-1:0]] <= in_req.fitness;
    end
    rd_data_r <= mem[rd_addr];
  end

  // generation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      best_slot_r <= '0;
      best_val_r  <= '0;
    end else if (cmd.load) begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      best_slot_r <= best_slot_nxt;
      best_val_r  <= best_val_nxt;
    end
  end

  // walk set-up and steps
  always_ff @(posedge clk) begin
    if (cmd.sel_begin) begin
      rhs_r <= rws_pkg::RHS_W'(in_req.random_fraction) * rws_pkg::RHS_W'(total_r);
      sum_r <= '0;
      idx_r <= '0;
    end else if (cmd.walk) begin
      sum_r <= sum_nxt;
      idx_r <= idx_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_r.kind           <= rws_pkg::KIND_LOAD;
      rsp_r.selected_index <= '0;
      rsp_r.best_index     <= best_slot_nxt;
      rsp_r.total_fitness  <= total_nxt;
      rsp_r.entry_total    <= count_nxt;
      rsp_r.overflow       <= full;
    end else if (cmd.sel_empty || (cmd.walk && status.walk_done)) begin
      rsp_r.kind           <= rws_pkg::KIND_SELECT;
      rsp_r.selected_index <= (cmd.walk && hit) ? idx_r : '0;
      rsp_r.best_index     <= best_slot_r;
      rsp_r.total_fitness  <= total_r;
      rsp_r.entry_total    <= count_r;
      rsp_r.overflow       <= 1'b0;
    end
  end

  assign out_rsp = rsp_r;

endmodule

// File: src/roulette_wheel_selection.sv
// Top level of the roulette wheel selection block.
// Depends on rws_pkg, rws_ctrl and rws_datapath.
//
//   channel   handshake          payload    direction
//   request   start / busy       in_req     in
//   result    out_valid strobe   out_rsp    out
//
// A load's result strobes in the next cycle.
// A select walks the store entry by entry, n entries (1..64), one
// store read and one add-and-compare a cycle; an empty store answers without a walk.
// The store's single read port paces the walk; busy is high while walking.
// Reset clears count, total and best; the store needs no clearing pass.
// Results are shown for one cycle only; the receiver cannot stall them.
module roulette_wheel_selection (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rws_pkg::in_req_t  in_req,
  output logic              out_valid,
  output rws_pkg::out_rsp_t out_rsp
);

  rws_pkg::dp_cmd_t    cmd;
  rws_pkg::dp_status_t status;

  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_req.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rws_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .status  (status),
    .out_rsp (out_rsp)
  );

  // no result is shown while a walk is in progress
  a_no_strobe_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while busy");

  // a load request is answered in the next cycle
  a_load_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.operation == rws_pkg::OP_LOAD)) |=> out_valid)
    else $error("load request not answered");

  // a select on a non-empty store starts a walk
  a_walk_started: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.operation == rws_pkg::OP_SELECT) && !status.count_zero)
      |=> busy)
    else $error("select did not start a walk");

  // chosen index lies inside the loaded population
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_rsp.selected_index} < out_rsp.entry_total) ||
                   (out_rsp.selected_index == '0)))
    else $error("selected index beyond entry count");

endmodule
